>>> src/four_wheel_drive_command_mixer_defines.svh
// assertion macros used by the top-level mixer rtl
`ifndef FOUR_WHEEL_DRIVE_COMMAND_MIXER_DEFINES_SVH
`define FOUR_WHEEL_DRIVE_COMMAND_MIXER_DEFINES_SVH

`ifndef ASSERT_OFF
`define FWDCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwdcm: same-cycle check failed");
`define FWDCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwdcm: next-cycle check failed");
`else
`define FWDCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FWDCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/fwdcm_pkg.sv
// types, codes and arithmetic helpers for the four wheel drive command mixer
package fwdcm_pkg;

    localparam int SPEED_W = 16;
    localparam int EXT_W   = SPEED_W + 2;
    localparam int CMP_W   = ((SPEED_W > 15) ? SPEED_W : 15) + 2;
    localparam int OUT_W   = 16;
    localparam int KEY_W   = 8;
    localparam int STEP_W  = 10;
    localparam int MAG_W   = 15;
    localparam int ACT_W   = 2;
    localparam int EN_W    = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_WHEELS = 4;

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [EXT_W-1:0]   t_ext;
    typedef logic signed [CMP_W-1:0]   t_cmp;
    typedef logic signed [OUT_W-1:0]   t_word;

    // key codes
    localparam logic [KEY_W-1:0] KEY_UP      = 8'd65;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 8'd66;
    localparam logic [KEY_W-1:0] KEY_RIGHT   = 8'd67;
    localparam logic [KEY_W-1:0] KEY_LEFT    = 8'd68;
    localparam logic [KEY_W-1:0] KEY_ENTER   = 8'd10;
    localparam logic [KEY_W-1:0] KEY_BALANCE = 8'h72;
    localparam logic [KEY_W-1:0] KEY_ACW_SLOW = 8'h71;
    localparam logic [KEY_W-1:0] KEY_CW_SLOW  = 8'h65;
    localparam logic [KEY_W-1:0] KEY_ACW_FAST = 8'h61;
    localparam logic [KEY_W-1:0] KEY_CW_FAST  = 8'h64;
    localparam logic [KEY_W-1:0] KEY_QUIT     = 8'h7a;

    // result actions
    localparam logic [ACT_W-1:0] ACT_STOP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SPIN = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUIT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_SLOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_FAST  = 8'd3;

    localparam logic [STEP_W-1:0] RST_SPEED_STEP = 10'd25;
    localparam logic [MAG_W-1:0]  RST_SPEED_LIM  = 15'd400;
    localparam logic [MAG_W-1:0]  RST_SPIN_SLOW  = 15'd100;
    localparam logic [MAG_W-1:0]  RST_SPIN_FAST  = 15'd300;

    typedef struct packed {
        logic [STEP_W-1:0] speed_step;
        logic [MAG_W-1:0]  speed_limit;
        logic [MAG_W-1:0]  spin_slow;
        logic [MAG_W-1:0]  spin_fast;
    } t_cfg;

    typedef struct packed {
        logic                       has;
        logic [ACT_W-1:0]           action;
        logic [NUM_WHEELS-1:0][OUT_W-1:0] words;
        logic [EN_W-1:0]            enables;
    } t_result;

    function automatic t_speed sat_speed(input t_ext v);
        t_ext hi;
        t_ext lo;
        hi = t_ext'({1'b0, {(SPEED_W-1){1'b1}}});
        lo = -hi - t_ext'(1);
        if (v > hi) begin
            return t_speed'(hi);
        end else if (v < lo) begin
            return t_speed'(lo);
        end
        return t_speed'(v);
    endfunction

    // halve, rounding toward zero
    function automatic t_ext halve(input t_speed w);
        t_ext e;
        e = t_ext'(w);
        return (e + t_ext'({1'b0, w[SPEED_W-1]})) >>> 1;
    endfunction

    function automatic logic [OUT_W-1:0] word_of(input t_speed s);
        t_cmp e;
        e = t_cmp'(s);
        return e[OUT_W-1:0];
    endfunction

    function automatic logic inside_limit(input t_speed s, input logic [MAG_W-1:0] lim);
        t_cmp e;
        t_cmp l;
        e = t_cmp'(s);
        l = t_cmp'({1'b0, lim});
        return (e > -l) && (e < l);
    endfunction

endpackage

>>> src/four_wheel_drive_command_mixer.sv
// an accepted key word is held in the input register, then its result in the result register
// throughput: one key word per cycle unless the output stalls, bounded by the speed update loop
// keys that give no result are consumed with nothing shown on the output
// reset (synchronous, active low) zeroes the speeds, clears the halt and loads register defaults
`include "four_wheel_drive_command_mixer_defines.svh"

module four_wheel_drive_command_mixer import fwdcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KEY_W-1:0]      i_key_code,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ACT_W-1:0]      o_action,
    output logic [OUT_W-1:0]      o_left_front_speed,
    output logic [OUT_W-1:0]      o_left_back_speed,
    output logic [OUT_W-1:0]      o_right_front_speed,
    output logic [OUT_W-1:0]      o_right_back_speed,
    output logic [EN_W-1:0]       o_write_enables,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    logic [KEY_W-1:0] r_key;
    logic             r_out_valid;
    t_result          r_out;
    t_result          res;
    t_cfg             cfg;
    logic             halted;
    logic             fire;
    logic             in_accept;
    logic             stop_shown;
    logic             stop_clean;

    // the key word in the input register is processed once the result register can take it
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_accept  = i_in_valid && o_in_ready;

    fwdcm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    fwdcm_mixer u_mixer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_key    (r_key),
        .i_cfg    (cfg),
        .o_res    (res),
        .o_halted (halted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.has) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.has) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_action            = r_out.action;
    assign o_left_front_speed  = r_out.words[0];
    assign o_left_back_speed   = r_out.words[1];
    assign o_right_front_speed = r_out.words[2];
    assign o_right_back_speed  = r_out.words[3];
    assign o_write_enables     = r_out.enables;

    assign stop_shown = o_out_valid && (o_action == ACT_STOP || o_action == ACT_QUIT);
    assign stop_clean = (o_write_enables == '0) && (r_out.words == '0);

    `FWDCM_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, halted, halted)
    `FWDCM_ASSERT_IMP(a_halt_silent, i_clk, i_rst_n, halted && fire, !res.has)
    `FWDCM_ASSERT_IMP(a_stop_zero, i_clk, i_rst_n, stop_shown, stop_clean)
    `FWDCM_ASSERT_IMP(a_spin_all_en, i_clk, i_rst_n, o_out_valid && o_action == ACT_SPIN, o_write_enables == '1)
    `FWDCM_ASSERT_NXT(a_key_held, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid && $stable(r_key))

endmodule

>>> src/fwdcm_cfg_regs.sv
// configuration register file
module fwdcm_cfg_regs import fwdcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_step  <= RST_SPEED_STEP;
            r_cfg.speed_limit <= RST_SPEED_LIM;
            r_cfg.spin_slow   <= RST_SPIN_SLOW;
            r_cfg.spin_fast   <= RST_SPIN_FAST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPEED_STEP: r_cfg.speed_step  <= i_cfg_data[STEP_W-1:0];
                REG_SPEED_LIM:  r_cfg.speed_limit <= i_cfg_data[MAG_W-1:0];
                REG_SPIN_SLOW:  r_cfg.spin_slow   <= i_cfg_data[MAG_W-1:0];
                REG_SPIN_FAST:  r_cfg.spin_fast   <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/fwdcm_mixer.sv
// wheel speed state, key decode and result formation
module fwdcm_mixer import fwdcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [KEY_W-1:0] i_key,
    input  t_cfg             i_cfg,
    output t_result          o_res,
    output logic             o_halted
);

    t_speed r_speed [NUM_WHEELS];
    t_speed n_speed [NUM_WHEELS];
    logic   r_halted;
    logic   n_halted;

    logic   set_result;
    logic   spin_result;
    logic   spin_cw;
    logic [MAG_W-1:0] spin_mag;
    t_word  spin_left;
    t_ext   step_ext;

    assign step_ext = t_ext'({1'b0, i_cfg.speed_step});

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_speed[i] = r_speed[i];
        end
        n_halted    = r_halted;
        set_result  = 1'b0;
        spin_result = 1'b0;
        spin_cw     = 1'b0;
        spin_mag    = i_cfg.spin_slow;
        o_res       = '0;

        if (!r_halted) begin
            unique case (i_key)
                KEY_UP: begin
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        n_speed[i] = sat_speed(t_ext'(r_speed[i]) + step_ext);
                    end
                    set_result = 1'b1;
                end
                KEY_DOWN: begin
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        n_speed[i] = sat_speed(t_ext'(r_speed[i]) - step_ext);
                    end
                    set_result = 1'b1;
                end
                KEY_LEFT: begin
                    // inner left wheels reverse at half the outer right speed
                    n_speed[0] = sat_speed(-halve(r_speed[2]));
                    n_speed[1] = sat_speed(-halve(r_speed[3]));
                    n_speed[2] = sat_speed(t_ext'(r_speed[2]) + halve(r_speed[2]));
                    n_speed[3] = sat_speed(t_ext'(r_speed[3]) + halve(r_speed[3]));
                    set_result = 1'b1;
                end
                KEY_RIGHT: begin
                    n_speed[2] = sat_speed(-halve(r_speed[0]));
                    n_speed[3] = sat_speed(-halve(r_speed[1]));
                    n_speed[0] = sat_speed(t_ext'(r_speed[0]) + halve(r_speed[0]));
                    n_speed[1] = sat_speed(t_ext'(r_speed[1]) + halve(r_speed[1]));
                    set_result = 1'b1;
                end
                KEY_BALANCE: begin
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        n_speed[i] = sat_speed(t_ext'(r_speed[0]) + t_ext'(r_speed[2]));
                    end
                    set_result = 1'b1;
                end
                KEY_ENTER: begin
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        n_speed[i] = '0;
                    end
                    o_res.has    = 1'b1;
                    o_res.action = ACT_STOP;
                end
                KEY_ACW_SLOW: begin
                    spin_result = 1'b1;
                end
                KEY_CW_SLOW: begin
                    spin_result = 1'b1;
                    spin_cw     = 1'b1;
                end
                KEY_ACW_FAST: begin
                    spin_result = 1'b1;
                    spin_mag    = i_cfg.spin_fast;
                end
                KEY_CW_FAST: begin
                    spin_result = 1'b1;
                    spin_cw     = 1'b1;
                    spin_mag    = i_cfg.spin_fast;
                end
                KEY_QUIT: begin
                    n_halted     = 1'b1;
                    o_res.has    = 1'b1;
                    o_res.action = ACT_QUIT;
                end
                default: ;
            endcase
        end

        spin_left = spin_cw ? -t_word'({1'b0, spin_mag}) : t_word'({1'b0, spin_mag});

        if (set_result) begin
            o_res.has    = 1'b1;
            o_res.action = ACT_SET;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                o_res.words[i]   = word_of(n_speed[i]);
                o_res.enables[i] = inside_limit(n_speed[i], i_cfg.speed_limit);
            end
        end

        if (spin_result) begin
            o_res.has      = 1'b1;
            o_res.action   = ACT_SPIN;
            o_res.words[0] = spin_left;
            o_res.words[1] = spin_left;
            o_res.words[2] = -spin_left;
            o_res.words[3] = -spin_left;
            o_res.enables  = '1;
        end
    end

    assign o_halted = r_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_speed[i] <= '0;
            end
            r_halted <= 1'b0;
        end else if (i_fire) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_speed[i] <= n_speed[i];
            end
            r_halted <= n_halted;
        end
    end

endmodule
